// File: sv/tjt_pkg.sv
// ----------------------------------------------------------------------------
// tjt_pkg
// Shared types, constants and time helpers for the timed job table.
// ----------------------------------------------------------------------------
package tjt_pkg;

  localparam int CAPACITY  = 16;
  localparam int TIME_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef logic [TIME_BITS-1:0] time_t;

  localparam time_t T_INF = '1;
  localparam time_t T_LIM = T_INF - time_t'(1);

  localparam logic [3:0] MODE_ADD       = 4'd0;
  localparam logic [3:0] MODE_ID_FADE   = 4'd1;
  localparam logic [3:0] MODE_ID_CUT    = 4'd2;
  localparam logic [3:0] MODE_TRK_FADE  = 4'd3;
  localparam logic [3:0] MODE_TRK_CUT   = 4'd4;
  localparam logic [3:0] MODE_ALL_FADE  = 4'd5;
  localparam logic [3:0] MODE_ALL_CUT   = 4'd6;
  localparam logic [3:0] MODE_COLLECT   = 4'd7;
  localparam logic [3:0] MODE_DUMP      = 4'd8;

  typedef struct packed {
    logic [15:0] id;
    logic        valid;
    logic [7:0]  clip;
    logic [3:0]  track;
    logic [15:0] weight;
    time_t       start;
    time_t       fade_in;
    time_t       fade_out;
    time_t       stop;
  } entry_t;

  typedef enum logic [2:0] {
    C_HOLD, C_LOAD, C_SHIFT_UP, C_SHIFT_DN, C_HALT, C_TRIM_LO, C_TRIM_HI
  } cell_op_t;

  typedef struct packed {
    time_t  now;
    logic   fade;
    entry_t new_e;
  } cell_ctl_t;

  function automatic time_t sat_add(time_t a, time_t b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, T_LIM}) ? T_LIM : s[TIME_BITS-1:0];
  endfunction

  function automatic time_t floor_sub(time_t a, time_t b);
    return (a > b) ? a - b : '0;
  endfunction

endpackage

// File: sv/tjt_cell.sv
// ----------------------------------------------------------------------------
// tjt_cell
// One table slot: holds an entry, shifts with its neighbors, halts and trims.
// ----------------------------------------------------------------------------
module tjt_cell (
  input  logic              clk,
  input  logic              rst,
  input  tjt_pkg::cell_op_t  op,
  input  tjt_pkg::cell_ctl_t ctl,
  input  tjt_pkg::entry_t    lo,
  input  tjt_pkg::entry_t    hi,
  output tjt_pkg::entry_t    q
);
  import tjt_pkg::*;

  entry_t halt_e;
  entry_t trim_lo_e;
  entry_t trim_hi_e;
  time_t  halt_end;

  always_comb begin
    halt_end = ctl.fade ? sat_add(ctl.now, floor_sub(q.stop, q.fade_out)) : ctl.now;
    halt_e = q;
    if (ctl.now < q.start) begin
      halt_e.valid = 1'b0;
    end else if (ctl.now < q.stop) begin
      halt_e.fade_out = ctl.now;
      halt_e.stop     = halt_end;
      halt_e.valid    = q.valid && (q.start < halt_end);
    end

    // earlier neighbor on the same track loses its tail
    trim_lo_e = q;
    if (q.valid && q.track == ctl.new_e.track) begin
      if (q.stop >= ctl.new_e.fade_in) begin
        trim_lo_e.stop     = ctl.new_e.fade_in;
        trim_lo_e.fade_out = ctl.new_e.start;
      end
      trim_lo_e.valid = trim_lo_e.start < trim_lo_e.stop;
    end

    // later neighbor loses its head
    trim_hi_e = q;
    if (q.valid && q.track == ctl.new_e.track) begin
      if (q.start <= ctl.new_e.fade_out) begin
        trim_hi_e.start   = ctl.new_e.fade_out;
        trim_hi_e.fade_in = ctl.new_e.stop;
      end
      trim_hi_e.valid = trim_hi_e.start < trim_hi_e.stop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      unique case (op)
        C_HOLD:     q <= q;
        C_LOAD:     q <= ctl.new_e;
        C_SHIFT_UP: q <= lo;
        C_SHIFT_DN: q <= hi;
        C_HALT:     q <= halt_e;
        C_TRIM_LO:  q <= trim_lo_e;
        C_TRIM_HI:  q <= trim_hi_e;
        default:    q <= q;
      endcase
    end
  end

endmodule

// File: sv/timed_job_table_with_overlap_trim_top.sv
// ----------------------------------------------------------------------------
// timed_job_table_with_overlap_trim_top
// Job table kept ordered by track and start, built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Use: one command word enters on s_t*; results leave on m_t*. Every command
// gives one result word with tlast set, except a dump of a non-empty table,
// which gives one word per entry in table order, tlast on the final one.
// From input accept to result: an add runs saturating sums, one
// registered 32x32 multiply, the insert shift and a trim pass; a collect
// squeezes out one dead entry per cycle by a shift down the cell chain;
// a dump rotates the chain one slot per word. One command is worked at a
// time; s_tready is high only while no command is in progress.
// Reset clears the entry count and all valid flags; the block is ready in
// the cycle after rst falls. When the receiver stalls, the result word holds
// in the output register and the sequencer waits before writing the next.
// ----------------------------------------------------------------------------
module timed_job_table_with_overlap_trim_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // mode, now_time, job_number, track, clip, weight, start_offset,
  // fade_in_len, fade_out_len, play_length, length_in_loops, clip_length
  input  logic [247:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // accepted, table_size, row_id, row_track, row_clip, row_weight, row_start,
  // row_fade_in_end, row_fade_out_start, row_end, row_valid
  output logic [183:0] m_tdata,
  output logic         m_tlast
);
  import tjt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD1, S_ADD2, S_ADD3, S_ADD4, S_STOP, S_COLLECT, S_DUMP, S_RESP
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [3:0]        mode;
  time_t             now;
  logic [15:0]       job;
  logic [3:0]        trk;
  logic [7:0]        clip;
  logic [15:0]       weight;
  time_t             offs, fin, fout, play, clen;
  logic              loops;
  time_t             st, fi, fo, en;
  logic [63:0]       prod;
  logic [IDX_W-1:0]  pos;
  logic [CNT_W-1:0]  didx;
  logic              acc;
  entry_t            o_row;
  logic              o_acc;
  logic [CNT_W-1:0]  o_size;

  entry_t            cell_q  [CAPACITY];
  entry_t            cell_lo [CAPACITY];
  entry_t            cell_hi [CAPACITY];
  cell_op_t          cell_op [CAPACITY];
  cell_ctl_t         ctl;

  logic [IDX_W-1:0]  pos_c;
  logic [IDX_W-1:0]  dead_pos;
  logic              any_dead;
  logic              found;
  logic              out_free;
  logic              out_load;
  logic [3:0]        in_mode;

  assign in_mode  = s_tdata[3:0];
  assign s_tready = (state == S_IDLE) && !rst;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && (state == S_DUMP || state == S_RESP);

  always_comb begin
    ctl.now            = now;
    ctl.fade           = (mode == MODE_ID_FADE) || (mode == MODE_TRK_FADE) ||
                         (mode == MODE_ALL_FADE);
    ctl.new_e.id       = job;
    ctl.new_e.valid    = 1'b1;
    ctl.new_e.clip     = clip;
    ctl.new_e.track    = trk;
    ctl.new_e.weight   = weight;
    ctl.new_e.start    = st;
    ctl.new_e.fade_in  = fi;
    ctl.new_e.fade_out = fo;
    ctl.new_e.stop     = en;
  end

  // insert position and first dead slot
  always_comb begin
    pos_c    = count[IDX_W-1:0];
    dead_pos = '0;
    any_dead = 1'b0;
    found    = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!found && CNT_W'(i) < count && cell_q[i].valid &&
          !(trk > cell_q[i].track) &&
          !(trk == cell_q[i].track && st > cell_q[i].start)) begin
        pos_c = IDX_W'(i);
        found = 1'b1;
      end
      if (!any_dead && CNT_W'(i) < count &&
          (!cell_q[i].valid || cell_q[i].stop < now)) begin
        dead_pos = IDX_W'(i);
        any_dead = 1'b1;
      end
    end
  end

  always_comb begin
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_op[i] = C_HOLD;
      unique case (state)
        S_ADD3: begin
          if (IDX_W'(i) == pos_c) cell_op[i] = C_LOAD;
          else if (IDX_W'(i) > pos_c && CNT_W'(i) <= count) cell_op[i] = C_SHIFT_UP;
        end
        S_ADD4: begin
          if (CNT_W'(i) < count && IDX_W'(i) != pos)
            cell_op[i] = (IDX_W'(i) < pos) ? C_TRIM_LO : C_TRIM_HI;
        end
        S_STOP: begin
          if (CNT_W'(i) < count) begin
            if (mode == MODE_ID_FADE || mode == MODE_ID_CUT) begin
              if (!hit && cell_q[i].id == job) begin
                cell_op[i] = C_HALT;
                hit = 1'b1;
              end
            end else if (mode == MODE_TRK_FADE || mode == MODE_TRK_CUT) begin
              if (cell_q[i].track == trk) cell_op[i] = C_HALT;
            end else begin
              cell_op[i] = C_HALT;
            end
          end
        end
        S_COLLECT: begin
          if (any_dead && IDX_W'(i) >= dead_pos && CNT_W'(i) < count)
            cell_op[i] = C_SHIFT_DN;
        end
        S_DUMP: begin
          if (out_free && CNT_W'(i) < count) cell_op[i] = C_SHIFT_DN;
        end
        default: cell_op[i] = C_HOLD;
      endcase
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_lo0
      assign cell_lo[g] = ctl.new_e;
    end else begin : g_lon
      assign cell_lo[g] = cell_q[g-1];
    end
    // top of the occupied run wraps to slot 0 so a dump rotates in place
    assign cell_hi[g] = (CNT_W'(g + 1) == count) ? cell_q[0]
                                                 : cell_q[(g + 1) % CAPACITY];
    tjt_cell u_cell (
      .clk (clk),
      .rst (rst),
      .op  (cell_op[g]),
      .ctl (ctl),
      .lo  (cell_lo[g]),
      .hi  (cell_hi[g]),
      .q   (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
      acc      <= 1'b1;
      didx     <= '0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            mode   <= in_mode;
            now    <= s_tdata[35:4];
            job    <= s_tdata[51:36];
            trk    <= s_tdata[55:52];
            clip   <= s_tdata[63:56];
            weight <= s_tdata[79:64];
            offs   <= s_tdata[111:80];
            fin    <= s_tdata[143:112];
            fout   <= s_tdata[175:144];
            play   <= s_tdata[207:176];
            loops  <= s_tdata[208];
            clen   <= s_tdata[240:209];
            acc    <= 1'b1;
            didx   <= '0;
            priority if (in_mode == MODE_ADD) state <= S_ADD1;
            else if (in_mode >= MODE_ID_FADE && in_mode <= MODE_ALL_CUT) state <= S_STOP;
            else if (in_mode == MODE_COLLECT) state <= S_COLLECT;
            else if (in_mode == MODE_DUMP && count != '0) state <= S_DUMP;
            else state <= S_RESP;
          end
        end
        S_ADD1: begin
          if (count >= CNT_W'(CAPACITY)) begin
            acc   <= 1'b0;
            state <= S_RESP;
          end else begin
            st    <= sat_add(now, offs);
            prod  <= play * clen;
            state <= S_ADD2;
          end
        end
        S_ADD2: begin
          fi <= sat_add(st, fin);
          if (play == '0) begin
            en <= T_INF;
            fo <= T_INF;
          end else begin
            en <= sat_add(st, loops ? prod[TIME_BITS+7:8] : play);
            fo <= floor_sub(sat_add(st, loops ? prod[TIME_BITS+7:8] : play), fout);
          end
          state <= S_ADD3;
        end
        S_ADD3: begin
          pos   <= pos_c;
          count <= count + CNT_W'(1);
          state <= S_ADD4;
        end
        S_ADD4:  state <= S_RESP;
        S_STOP:  state <= S_RESP;
        S_COLLECT: begin
          if (any_dead) count <= count - CNT_W'(1);
          else state <= S_RESP;
        end
        S_DUMP: begin
          if (out_free) begin
            o_acc    <= 1'b1;
            o_size   <= count;
            o_row    <= cell_q[0];
            m_tlast  <= (didx + CNT_W'(1) == count);
            didx     <= didx + CNT_W'(1);
            if (didx + CNT_W'(1) == count) state <= S_IDLE;
          end
        end
        S_RESP: begin
          if (out_free) begin
            o_acc    <= acc;
            o_size   <= count;
            o_row    <= '0;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {5'd0, o_row.valid, o_row.stop, o_row.fade_out, o_row.fade_in,
                    o_row.start, o_row.weight, o_row.clip, o_row.track, o_row.id,
                    o_size, o_acc};

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_reject_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tlast)
    else $error("rejected add gave more than one word");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_ADD3 |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the table");

endmodule
